FILE: design/olt_pkg.sv
`timescale 1ns / 1ps

package olt_pkg;

	localparam int DEPTH     = 16;
	localparam int WORD_BITS = 32;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int POS_W     = 5;
	localparam int LIM_W     = 5;
	localparam int CMP_W     = (CNT_W > POS_W) ? ((CNT_W > LIM_W) ? CNT_W : LIM_W)
		: ((POS_W > LIM_W) ? POS_W : LIM_W);
	localparam int FUNC_W    = 3;

	// tdata layout, lowest bit first
	localparam int IN_BITS   = FUNC_W + POS_W + WORD_BITS;
	localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS  = 1 + WORD_BITS + 1 + IDX_W + CNT_W;
	localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

	localparam int ADDR_W    = 3;
	localparam int REG_LIMIT = 0;
	localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(16);

	typedef enum logic [FUNC_W-1:0] {
		FN_APPEND    = 3'd0,
		FN_REMOVE    = 3'd1,
		FN_FIND      = 3'd2,
		FN_READ      = 3'd3,
		FN_OVERWRITE = 3'd4,
		FN_DELETE    = 3'd5,
		FN_INSERT    = 3'd6
	} func_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_WRITE  = 2'd1,
		CELL_DELETE = 2'd2,
		CELL_INSERT = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t               op;
		logic [IDX_W-1:0]       idx;
		logic [WORD_BITS-1:0]   word;
	} cell_cmd_t;

endpackage

FILE: design/ordered_list_table_engine.sv
// A request accepted at a clock edge shows its response on m_tdata right after that edge.
// Throughput: one request per cycle; every operation, shifts and search included, finishes in
//   the single update of the cell row, so only a stalled response register holds off s_tready.
// Reset (arst_n low, asynchronous): entry count 0, size limit 16, no response pending.
//   Entry words are not reset; only entries below the count are ever read.
`timescale 1ns / 1ps

module ordered_list_table_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	// request stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [olt_pkg::IN_W-1:0]    s_tdata,   // func[2:0], position[7:3], word_in[39:8]
	// response stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [olt_pkg::OUT_W-1:0]   m_tdata,   // status[0], word_out[32:1], hit[33],
	                                               // hit_index[37:34], entry_count[42:38]
	// config port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [olt_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import olt_pkg::*;

	// request fields
	logic [FUNC_W-1:0]    func;
	logic [POS_W-1:0]     position;
	logic [WORD_BITS-1:0] word_in;

	assign func     = s_tdata[FUNC_W-1:0];
	assign position = s_tdata[FUNC_W+POS_W-1:FUNC_W];
	assign word_in  = s_tdata[FUNC_W+POS_W+WORD_BITS-1:FUNC_W+POS_W];

	// ---------------------------------------------------------------
	// Config register: size_limit at byte address 0
	// ---------------------------------------------------------------
	logic [LIM_W-1:0] limit_q;
	logic             reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[ADDR_W-1:2] == (ADDR_W-2)'(REG_LIMIT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			limit_q <= pwdata[LIM_W-1:0];
		end
	end

	assign prdata = reg_hit ? 32'(limit_q) : 32'd0;

	// ---------------------------------------------------------------
	// Handshake: one response register; a new request enters whenever
	// that register is empty or is being drained in the same cycle.
	// ---------------------------------------------------------------
	logic out_valid_q;
	logic accept;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	// ---------------------------------------------------------------
	// Decode against the live count
	// ---------------------------------------------------------------
	logic [CNT_W-1:0] count_q;
	logic [CMP_W-1:0] lim;
	logic [CMP_W-1:0] cnt_x;
	logic [CMP_W-1:0] pos_x;
	logic             full;
	logic             pos_in;    // position names a live entry
	logic             pos_ins;   // position valid for insert (may equal count)

	always_comb begin
		if (limit_q == '0)                  lim = CMP_W'(1);
		else if (CMP_W'(limit_q) > CMP_W'(DEPTH)) lim = CMP_W'(DEPTH);
		else                                lim = CMP_W'(limit_q);
	end

	assign cnt_x   = CMP_W'(count_q);
	assign pos_x   = CMP_W'(position);
	assign full    = (cnt_x >= lim);
	assign pos_in  = (pos_x < cnt_x);
	assign pos_ins = (pos_x <= cnt_x);

	cell_cmd_t        cmd;
	logic             ok;
	logic             rd_en;
	logic [IDX_W-1:0] rd_idx;
	logic [CNT_W-1:0] count_nxt;

	always_comb begin
		cmd.op    = CELL_HOLD;
		cmd.idx   = IDX_W'(position);
		cmd.word  = word_in;
		ok        = 1'b0;
		rd_en     = 1'b0;
		rd_idx    = IDX_W'(position);
		count_nxt = count_q;
		case (func)
			FN_APPEND: begin
				if (!full) begin
					ok        = 1'b1;
					cmd.op    = CELL_WRITE;
					cmd.idx   = IDX_W'(count_q);
					count_nxt = count_q + CNT_W'(1);
				end
			end
			FN_REMOVE: begin
				if (count_q != '0) begin
					ok        = 1'b1;
					rd_en     = 1'b1;
					rd_idx    = IDX_W'(count_q - CNT_W'(1));
					count_nxt = count_q - CNT_W'(1);
				end
			end
			FN_FIND: begin
				ok = 1'b1;
			end
			FN_READ: begin
				if (pos_in) begin
					ok    = 1'b1;
					rd_en = 1'b1;
				end
			end
			FN_OVERWRITE: begin
				if (pos_in) begin
					ok     = 1'b1;
					cmd.op = CELL_WRITE;
				end
			end
			FN_DELETE: begin
				if (pos_in) begin
					ok        = 1'b1;
					cmd.op    = CELL_DELETE;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			FN_INSERT: begin
				if (pos_ins && !full) begin
					ok        = 1'b1;
					cmd.op    = CELL_INSERT;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		// the row only moves on an accepted request
		if (!accept) cmd.op = CELL_HOLD;
	end

	// ---------------------------------------------------------------
	// Cell row: each cell holds one entry and sees both neighbors.
	// Delete pulls from the right, insert pushes from the left.
	// ---------------------------------------------------------------
	logic [WORD_BITS-1:0] cell_word [DEPTH];
	logic [DEPTH-1:0]     cell_match;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_BITS-1:0] left_w;
		logic [WORD_BITS-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = word_in;
		end else begin : g_mid_l
			assign left_w = cell_word[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = cell_word[i];
		end else begin : g_mid_r
			assign right_w = cell_word[i+1];
		end
		olt_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.index      (IDX_W'(i)),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (cell_word[i]),
			.match      (cell_match[i])
		);
	end

	// first live match wins
	logic             hit;
	logic [IDX_W-1:0] hit_idx;

	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (cell_match[i] && (CMP_W'(i) < cnt_x)) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(i);
			end
		end
	end

	// ---------------------------------------------------------------
	// Count and response registers
	// ---------------------------------------------------------------
	logic                 status_q;
	logic [WORD_BITS-1:0] word_out_q;
	logic                 hit_q;
	logic [IDX_W-1:0]     hit_idx_q;
	logic [CNT_W-1:0]     cnt_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q   <= !ok;
			word_out_q <= rd_en ? cell_word[rd_idx] : '0;
			hit_q      <= (func == FN_FIND) && hit;
			hit_idx_q  <= (func == FN_FIND && hit) ? hit_idx : '0;
			cnt_out_q  <= count_nxt;
		end
	end

	assign m_tdata = OUT_W'({cnt_out_q, hit_idx_q, hit_q, word_out_q, status_q});

endmodule

FILE: design/olt_cell.sv
`timescale 1ns / 1ps

module olt_cell (
	input  logic                          clk,
	input  olt_pkg::cell_cmd_t            cmd,
	input  logic [olt_pkg::IDX_W-1:0]     index,
	input  logic [olt_pkg::WORD_BITS-1:0] left_word,
	input  logic [olt_pkg::WORD_BITS-1:0] right_word,
	output logic [olt_pkg::WORD_BITS-1:0] word,
	output logic                          match
);
	import olt_pkg::*;

	logic [WORD_BITS-1:0] word_q;

	// payload only, no reset
	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_WRITE: begin
				if (index == cmd.idx) word_q <= cmd.word;
			end
			CELL_DELETE: begin
				if (index >= cmd.idx) word_q <= right_word;
			end
			CELL_INSERT: begin
				if (index == cmd.idx) word_q <= cmd.word;
				else if (index > cmd.idx) word_q <= left_word;
			end
			default: begin
				word_q <= word_q;
			end
		endcase
	end

	assign word  = word_q;
	assign match = (word_q == cmd.word);

endmodule

FILE: design/olt_checker.sv
`timescale 1ns / 1ps

module olt_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [olt_pkg::OUT_W-1:0] m_tdata
);
	import olt_pkg::*;

	localparam int CNT_LO = 1 + WORD_BITS + 1 + IDX_W;

	// stalled response holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("response changed while stalled");

	// an accepted request always yields a response next cycle
	a_resp: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted request produced no response");

	// empty response slot never blocks requests
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("request blocked with empty response slot");

	// refused request reports no word and no hit
	a_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[WORD_BITS+1:1] == '0)
		else $error("refused request carries data");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[CNT_LO+CNT_W-1:CNT_LO] <= CNT_W'(DEPTH))
		else $error("entry count beyond depth");

endmodule

bind ordered_list_table_engine olt_checker u_olt_checker (.*);
